FILE: hw/rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg - shared definitions for the bounded ordered list
// Sizes, operation and status codes, cell select codes and helpers.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // width for comparing positions against the fill count
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [2:0]               t_sel;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_AFTER = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DISPLAY   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // cell next-value select
    localparam t_sel SEL_HOLD = 3'd0;
    localparam t_sel SEL_VAL  = 3'd1;
    localparam t_sel SEL_PREV = 3'd2;
    localparam t_sel SEL_NEXT = 3'd3;
    localparam t_sel SEL_HEAD = 3'd4;

    // length as reported: fill count modulo 32
    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] c);
        logic [CNT_W+LEN_W-1:0] ext;
        ext = {{LEN_W{1'b0}}, c};
        return ext[LEN_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/bol_cell.sv
// ----------------------------------------------------------------------------
// bol_cell - one storage cell of the list chain
// Holds one entry and loads it from the insert value, a neighbour or the head cell.
// ----------------------------------------------------------------------------
module bol_cell
    import bol_pkg::*;
(
    input  logic  i_clk,
    input  t_sel  i_sel,
    input  t_data i_value,
    input  t_data i_prev,
    input  t_data i_next,
    input  t_data i_head,
    output t_data o_data
);

    t_data r_data;
    t_data n_data;

    always_comb begin
        case (i_sel)
            SEL_VAL:  n_data = i_value;
            SEL_PREV: n_data = i_prev;
            SEL_NEXT: n_data = i_next;
            SEL_HEAD: n_data = i_head;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: hw/rtl/bounded_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit - ordered list of signed values in a cell chain
// Insert front/end, delete front, delete after a position, and display.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  command  | in        | start, busy         | i_func, i_value, i_position
//  result   | out       | o_strobe (one cycle) | o_status, o_element, o_last,
//           |           |                     | o_length
//
//  A command beat is taken on a rising edge with start high and busy low.
//  Insert and delete commands complete on the accepting edge: the cell row
//  shifts or loads on that edge and the status beat appears on the next cycle.
//  Display of a non-empty list: busy stays high while the row rotates one
//  place a cycle and cell 0 feeds each element out, leaving the list as it
//  was; the first element beat passes through the state register and then
//  the result beat register. An empty display gives its one beat on the
//  next cycle. Unused function codes are taken and give no beat.
//  Reset (synchronous, active low) empties the list; entries are not cleared.
//  The receiver cannot stall: each result beat lasts exactly one cycle.
// ----------------------------------------------------------------------------
module bounded_ordered_list_unit
    import bol_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_strobe,
    output logic [STAT_W-1:0]       o_status,
    output logic signed [DATA_W-1:0] o_element,
    output logic                    o_last,
    output logic [LEN_W-1:0]        o_length
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DISP = 1'b1;

    // control state
    logic              r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [CNT_W-1:0]  r_idx,    n_idx;
    logic              r_strobe, n_strobe;

    // result beat register
    logic [STAT_W-1:0] r_status, n_status;
    t_data             r_element, n_element;
    logic              r_last,   n_last;
    logic [LEN_W-1:0]  r_length, n_length;

    logic              accept;
    logic              full;
    logic              empty;
    logic              range_bad;
    logic              disp_last;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;

    t_data             cell_q   [DEPTH];
    t_sel              cell_sel [DEPTH];

    assign busy      = (r_state == S_DISP);
    assign accept    = start && !busy;
    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign pos_ext   = CMP_W'(i_position);
    assign cnt_ext   = CMP_W'(r_count);
    // the position has no successor in the list
    assign range_bad = ((pos_ext + CMP_W'(1)) >= cnt_ext);
    assign disp_last = (r_idx == (r_count - CNT_W'(1)));

    // ------------------------------------------------------------------------
    // Sequencer: list commands and display stepping
    // ------------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_element = '0;
        n_last    = 1'b1;
        n_length  = to_len(r_count);

        if (r_state == S_DISP) begin
            // emit the current head, rotate the row one place
            n_strobe  = 1'b1;
            n_element = cell_q[0];
            n_last    = disp_last;
            n_idx     = r_idx + CNT_W'(1);
            if (disp_last) begin
                n_state = S_IDLE;
            end
        end else if (accept) begin
            case (i_func)
                FN_INS_FRONT, FN_INS_END: begin
                    n_strobe = 1'b1;
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                FN_DEL_FRONT: begin
                    n_strobe = 1'b1;
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                FN_DEL_AFTER: begin
                    n_strobe = 1'b1;
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else if (range_bad) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                FN_DISPLAY: begin
                    if (empty) begin
                        // a single empty beat
                        n_strobe = 1'b1;
                        n_status = ST_EMPTY;
                    end else begin
                        n_state = S_DISP;
                        n_idx   = '0;
                    end
                end
                default: begin
                    // unused code: drop the beat
                end
            endcase
            n_length = to_len(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_element <= n_element;
        r_last    <= n_last;
        r_length  <= n_length;
    end

    // ------------------------------------------------------------------------
    // Cell row: each cell picks its next value from its index, the state, the command, the fill count and the position
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CMP_W-1:0] K = CMP_W'(g);
        localparam int PREV_I = (g == 0) ? 0 : g - 1;
        localparam int NEXT_I = (g == DEPTH - 1) ? g : g + 1;

        t_data prev_d;

        // the front cell takes the insert value in place of a left neighbour
        assign prev_d = (g == 0) ? i_value : cell_q[PREV_I];

        always_comb begin
            cell_sel[g] = SEL_HOLD;
            if (r_state == S_DISP) begin
                // rotate the occupied part left, head wraps to the tail
                if ((K + CMP_W'(1)) < cnt_ext) begin
                    cell_sel[g] = SEL_NEXT;
                end else if ((K + CMP_W'(1)) == cnt_ext) begin
                    cell_sel[g] = SEL_HEAD;
                end
            end else if (accept) begin
                case (i_func)
                    FN_INS_FRONT: begin
                        if (!full && K <= cnt_ext) begin
                            cell_sel[g] = (g == 0) ? SEL_VAL : SEL_PREV;
                        end
                    end
                    FN_INS_END: begin
                        if (!full && K == cnt_ext) begin
                            cell_sel[g] = SEL_VAL;
                        end
                    end
                    FN_DEL_FRONT: begin
                        if ((K + CMP_W'(1)) < cnt_ext) begin
                            cell_sel[g] = SEL_NEXT;
                        end
                    end
                    FN_DEL_AFTER: begin
                        if (K > pos_ext && (K + CMP_W'(1)) < cnt_ext) begin
                            cell_sel[g] = SEL_NEXT;
                        end
                    end
                    default: begin
                        cell_sel[g] = SEL_HOLD;
                    end
                endcase
            end
        end

        bol_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (cell_sel[g]),
            .i_value (i_value),
            .i_prev  (prev_d),
            .i_next  (cell_q[NEXT_I]),
            .i_head  (cell_q[0]),
            .o_data  (cell_q[g])
        );
    end

    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_last    = r_last;
    assign o_length  = r_length;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_mid_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final beat outside display");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> o_last)
        else $error("error beat not marked last");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_func == FN_INS_FRONT || i_func == FN_INS_END))
        |=> (o_strobe && o_status == ST_FULL && $stable(r_count)))
        else $error("insert into full list changed the list");

endmodule
